@@ rtl/tms_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and constants for the two-symbol Turing machine stepper.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int MAX_STATES = 32;
  localparam int TAPE_CELLS = 4096;

  localparam int STATE_W    = 5;
  localparam int SLOT_W     = 6;
  localparam int RULE_SLOTS = 2 * MAX_STATES;
  localparam int RULE_W     = 8;
  localparam int HEAD_W     = 12;
  localparam int ONES_W     = 13;
  localparam int STEP_W     = 48;
  localparam int ACT_W      = 6;
  localparam int APB_AW     = 2;
  localparam int APB_DW     = 32;

  localparam logic [STEP_W-1:0] STEP_MAX    = {STEP_W{1'b1}};
  localparam logic [HEAD_W-1:0] HEAD_CENTER = HEAD_W'(TAPE_CELLS / 2);
  localparam logic [HEAD_W-1:0] HEAD_LAST   = HEAD_W'(TAPE_CELLS - 1);
  localparam logic [ACT_W-1:0]  ACT_RESET   = ACT_W'(3);
  localparam logic [ACT_W-1:0]  ACT_LIMIT   = ACT_W'(MAX_STATES);

  localparam logic [APB_AW-1:0] ADDR_ACTIVE_STATES = APB_AW'(0);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  localparam logic [1:0] MOVE_LEFT  = 2'd0;
  localparam logic [1:0] MOVE_RIGHT = 2'd1;

  typedef struct packed {
    logic [1:0]         op;
    logic [SLOT_W-1:0]  rule_index;
    logic               rule_write;
    logic [1:0]         rule_move;
    logic [STATE_W-1:0] rule_next;
  } in_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] state_now;
    logic [HEAD_W-1:0]  head_now;
    logic               symbol_read;
    logic               symbol_written;
    logic [ONES_W-1:0]  ones_now;
    logic [STEP_W-1:0]  steps_now;
    logic               halted;
    logic               hit_edge;
    logic               bad_rule;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/tms_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface tms_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [tms_pkg::SLOT_W-1:0]    rule_index;
  logic                          rule_write;
  logic [1:0]                    rule_move;
  logic [tms_pkg::STATE_W-1:0]   rule_next;

  modport source (output valid, op, rule_index, rule_write, rule_move, rule_next,
                  input ready);
  modport sink (input valid, op, rule_index, rule_write, rule_move, rule_next,
                output ready);
endinterface

@@ rtl/tms_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_out_if
// Result item channel: valid/ready handshake with the status fields.
// ----------------------------------------------------------------------------
interface tms_out_if;
  logic                          valid;
  logic                          ready;
  logic [tms_pkg::STATE_W-1:0]   state_now;
  logic [tms_pkg::HEAD_W-1:0]    head_now;
  logic                          symbol_read;
  logic                          symbol_written;
  logic [tms_pkg::ONES_W-1:0]    ones_now;
  logic [tms_pkg::STEP_W-1:0]    steps_now;
  logic                          halted;
  logic                          hit_edge;
  logic                          bad_rule;

  modport source (output valid, state_now, head_now, symbol_read, symbol_written,
                  ones_now, steps_now, halted, hit_edge, bad_rule,
                  input ready);
  modport sink (input valid, state_now, head_now, symbol_read, symbol_written,
                ones_now, steps_now, halted, hit_edge, bad_rule,
                output ready);
endinterface

@@ rtl/tms_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_ctrl
// Sequencer: takes one item, lets the memory reads register, then commits
// once the result register is free.
// ----------------------------------------------------------------------------
module tms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tms_pkg::dp_status_t status,
  output tms_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    cmd.accept = in_valid && (state_r == S_IDLE);
    cmd.commit = (state_r == S_EXEC) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd.accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          // hold until the previous result has been taken
          if (cmd.commit) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ rtl/tms_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tms_dp
// Datapath: rule and tape memories, machine registers, step logic and the
// result register.
// ----------------------------------------------------------------------------
module tms_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tms_pkg::ctrl_cmd_t            cmd,
  output tms_pkg::dp_status_t           status,
  input  tms_pkg::in_item_t             in_item,
  input  logic [tms_pkg::ACT_W-1:0]     active_states,
  output tms_pkg::out_item_t            out_item,
  output logic                          out_valid,
  input  logic                          out_ready
);

  // memories
  logic                         tape_mem [tms_pkg::TAPE_CELLS];
  logic [tms_pkg::RULE_W-1:0]   rule_mem [tms_pkg::RULE_SLOTS];

  tms_pkg::in_item_t            item_r;
  logic                         tape_rd_r;
  logic [tms_pkg::RULE_W-1:0]   rule0_rd_r;
  logic [tms_pkg::RULE_W-1:0]   rule1_rd_r;

  logic [tms_pkg::STATE_W-1:0]  state_r, state_nxt;
  logic [tms_pkg::HEAD_W-1:0]   head_r, head_nxt;
  logic [tms_pkg::ONES_W-1:0]   ones_r, ones_nxt;
  logic [tms_pkg::STEP_W-1:0]   steps_r, steps_nxt;
  logic                         halted_r, halted_nxt;
  logic                         edge_r, edge_nxt;
  logic                         bad_r, bad_nxt;
  // span of tape cells written since restart; cells outside read as zero
  logic                         wr_any_r, wr_any_nxt;
  logic [tms_pkg::HEAD_W-1:0]   wr_lo_r, wr_lo_nxt;
  logic [tms_pkg::HEAD_W-1:0]   wr_hi_r, wr_hi_nxt;

  tms_pkg::out_item_t           out_item_r;
  logic                         out_valid_r;

  logic                         cell_ok;
  logic                         sym;
  logic [tms_pkg::RULE_W-1:0]   rule;
  logic                         wsym;
  logic [1:0]                   mv;
  logic [tms_pkg::STATE_W-1:0]  nxt_state;
  logic                         step_go;
  logic                         load_go;

  assign status.out_free = !out_valid_r || out_ready;
  assign out_item        = out_item_r;
  assign out_valid       = out_valid_r;

  always_comb begin
    cell_ok   = wr_any_r && (head_r >= wr_lo_r) && (head_r <= wr_hi_r);
    sym       = cell_ok && tape_rd_r;
    rule      = sym ? rule1_rd_r : rule0_rd_r;
    wsym      = rule[0];
    mv        = rule[2:1];
    nxt_state = rule[7:3];
    step_go   = (item_r.op == tms_pkg::OP_STEP) && !halted_r;
    load_go   = (item_r.op == tms_pkg::OP_LOAD);

    state_nxt  = state_r;
    head_nxt   = head_r;
    ones_nxt   = ones_r;
    steps_nxt  = steps_r;
    halted_nxt = halted_r;
    edge_nxt   = edge_r;
    bad_nxt    = bad_r;
    wr_any_nxt = wr_any_r;
    wr_lo_nxt  = wr_lo_r;
    wr_hi_nxt  = wr_hi_r;

    if (item_r.op == tms_pkg::OP_RESTART) begin
      state_nxt  = '0;
      head_nxt   = tms_pkg::HEAD_CENTER;
      ones_nxt   = '0;
      steps_nxt  = '0;
      halted_nxt = 1'b0;
      edge_nxt   = 1'b0;
      bad_nxt    = 1'b0;
      wr_any_nxt = 1'b0;
    end else if (step_go) begin
      // grow the written span around the head
      wr_any_nxt = 1'b1;
      if (!wr_any_r || head_r < wr_lo_r) begin
        wr_lo_nxt = head_r;
      end
      if (!wr_any_r || head_r > wr_hi_r) begin
        wr_hi_nxt = head_r;
      end

      if (!sym && wsym) begin
        ones_nxt = ones_r + tms_pkg::ONES_W'(1);
      end else if (sym && !wsym && ones_r != '0) begin
        ones_nxt = ones_r - tms_pkg::ONES_W'(1);
      end
      if (steps_r != tms_pkg::STEP_MAX) begin
        steps_nxt = steps_r + tms_pkg::STEP_W'(1);
      end

      if (mv == tms_pkg::MOVE_LEFT || mv == tms_pkg::MOVE_RIGHT) begin
        if (mv == tms_pkg::MOVE_LEFT) begin
          if (head_r == '0) begin
            edge_nxt   = 1'b1;
            halted_nxt = 1'b1;
          end else begin
            head_nxt = head_r - tms_pkg::HEAD_W'(1);
          end
        end else begin
          if (head_r >= tms_pkg::HEAD_LAST) begin
            edge_nxt   = 1'b1;
            halted_nxt = 1'b1;
          end else begin
            head_nxt = head_r + tms_pkg::HEAD_W'(1);
          end
        end
        if (({1'b0, nxt_state} >= active_states) ||
            ({1'b0, nxt_state} >= tms_pkg::ACT_LIMIT)) begin
          bad_nxt    = 1'b1;
          halted_nxt = 1'b1;
        end else begin
          state_nxt = nxt_state;
        end
      end else begin
        halted_nxt = 1'b1;
      end
    end
  end

  // tape memory: read on accept, write back on step commit
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tape_rd_r <= tape_mem[head_r];
    end
    if (cmd.commit && step_go) begin
      tape_mem[head_r] <= wsym;
    end
  end

  // rule memory: fetch both state slots on accept, write on load commit
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rule0_rd_r <= rule_mem[{state_r, 1'b0}];
      rule1_rd_r <= rule_mem[{state_r, 1'b1}];
    end
    if (cmd.commit && load_go) begin
      rule_mem[item_r.rule_index] <= {item_r.rule_next, item_r.rule_move,
                                       item_r.rule_write};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_item;
    end
    if (cmd.commit) begin
      out_item_r.state_now      <= state_nxt;
      out_item_r.head_now       <= head_nxt;
      out_item_r.symbol_read    <= step_go && sym;
      out_item_r.symbol_written <= step_go && wsym;
      out_item_r.ones_now       <= ones_nxt;
      out_item_r.steps_now      <= steps_nxt;
      out_item_r.halted         <= halted_nxt;
      out_item_r.hit_edge       <= edge_nxt;
      out_item_r.bad_rule       <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      head_r      <= tms_pkg::HEAD_CENTER;
      ones_r      <= '0;
      steps_r     <= '0;
      halted_r    <= 1'b1;
      edge_r      <= 1'b0;
      bad_r       <= 1'b0;
      wr_any_r    <= 1'b0;
      wr_lo_r     <= tms_pkg::HEAD_CENTER;
      wr_hi_r     <= tms_pkg::HEAD_CENTER;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        state_r  <= state_nxt;
        head_r   <= head_nxt;
        ones_r   <= ones_nxt;
        steps_r  <= steps_nxt;
        halted_r <= halted_nxt;
        edge_r   <= edge_nxt;
        bad_r    <= bad_nxt;
        wr_any_r <= wr_any_nxt;
        wr_lo_r  <= wr_lo_nxt;
        wr_hi_r  <= wr_hi_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_flag_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (edge_r || bad_r) |-> halted_r)
    else $error("stop flag set while machine runs");

  a_head_near_span: assert property (@(posedge clk) disable iff (!rst_n)
    wr_any_r |-> (({1'b0, head_r} + 13'd1 >= {1'b0, wr_lo_r}) &&
                  ({1'b0, head_r} <= {1'b0, wr_hi_r} + 13'd1)))
    else $error("head left the written span by more than one cell");

  a_ones_need_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (steps_r == '0) |-> (ones_r == '0))
    else $error("ones counted without any step");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed item did not reach the result register");
`endif

endmodule

@@ rtl/turing_machine_stepper_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turing_machine_stepper_core
// Two-symbol Turing machine stepper with rule loading and an APB register.
// ----------------------------------------------------------------------------
// When the result register is free, the accept cycle reads the tape cell under
// the head and both rule slots of the current state from their memories, and
// the next cycle picks the rule, writes the tape back, updates the machine and
// loads the result register. The read-then-write of the single-port tape
// memory, with the next read needing the new head and state, keeps a new item
// out until the last one has committed. A result waiting on the output holds
// the commit. A restart needs no clearing pass: the tape keeps the span of
// cells written since restart, and any cell outside it reads as zero.
module turing_machine_stepper_core (
  input  logic                          clk,
  input  logic                          rst_n,
  tms_in_if.sink                        in_chan,
  tms_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tms_pkg::APB_AW-1:0]    paddr,
  input  logic [tms_pkg::APB_DW-1:0]    pwdata,
  output logic [tms_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  logic [tms_pkg::ACT_W-1:0] active_states_r;
  tms_pkg::ctrl_cmd_t        cmd;
  tms_pkg::dp_status_t       status;
  tms_pkg::in_item_t         in_item;
  tms_pkg::out_item_t        out_item;
  logic                      in_ready;
  logic                      out_valid;
  logic                      apb_hit;
  logic                      apb_wr;

  assign pready  = 1'b1;
  assign apb_hit = (paddr == tms_pkg::ADDR_ACTIVE_STATES);
  assign apb_wr  = psel && penable && pwrite && pready && apb_hit;
  assign prdata  = apb_hit ? {{(tms_pkg::APB_DW - tms_pkg::ACT_W){1'b0}}, active_states_r}
                           : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_states_r <= tms_pkg::ACT_RESET;
    end else if (apb_wr) begin
      active_states_r <= pwdata[tms_pkg::ACT_W-1:0];
    end
  end

  always_comb begin
    in_item.op         = in_chan.op;
    in_item.rule_index = in_chan.rule_index;
    in_item.rule_write = in_chan.rule_write;
    in_item.rule_move  = in_chan.rule_move;
    in_item.rule_next  = in_chan.rule_next;
  end

  assign in_chan.ready = in_ready;

  assign out_chan.valid          = out_valid;
  assign out_chan.state_now      = out_item.state_now;
  assign out_chan.head_now       = out_item.head_now;
  assign out_chan.symbol_read    = out_item.symbol_read;
  assign out_chan.symbol_written = out_item.symbol_written;
  assign out_chan.ones_now       = out_item.ones_now;
  assign out_chan.steps_now      = out_item.steps_now;
  assign out_chan.halted         = out_item.halted;
  assign out_chan.hit_edge       = out_item.hit_edge;
  assign out_chan.bad_rule       = out_item.bad_rule;

  tms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tms_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_item       (in_item),
    .active_states (active_states_r),
    .out_item      (out_item),
    .out_valid     (out_valid),
    .out_ready     (out_chan.ready)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for turing_machine_stepper_core. Items go in through the
// input channel under random sender gaps and receiver stalls. A scoreboard
// class keeps its own copy of the rule table, tape, head, counters and flags.
// It predicts one status item for every accepted input item and compares each
// returned status field by field. active_states is changed through the APB
// port between phases and read back. Stimulus opens with directed items:
// steps while halted, ignored ops, a halt rule, move code three, a bad next
// state and the extreme rule slots. Random busy-beaver style programs follow,
// each one loaded, restarted and stepped.
// ----------------------------------------------------------------------------
module testbench;
  import tms_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] MOVE_HALT  = 2'd2;
  localparam logic [1:0] MOVE_SPARE = 2'd3;

  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 180;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES    = 9;

  // bit 0 write, bits 2..1 move, bits 7..3 next state
  typedef struct packed {
    logic [STATE_W-1:0] nxt;
    logic [1:0]         mv;
    logic               wr;
  } tm_rule_t;

  class tm_scoreboard;
    tm_rule_t           rules[RULE_SLOTS];
    bit                 loaded[RULE_SLOTS];
    bit                 tape[TAPE_CELLS];
    logic [STATE_W-1:0] state;
    logic [HEAD_W-1:0]  head;
    logic [ONES_W-1:0]  ones;
    logic [STEP_W-1:0]  steps;
    bit                 halted;
    bit                 at_edge;
    bit                 bad;
    logic [ACT_W-1:0]   active;
    out_item_t          status_due[$];
    int                 errors;

    function new();
      foreach (loaded[i]) loaded[i] = 1'b0;
      foreach (rules[i]) rules[i] = '0;
      active = ACT_RESET;
      errors = 0;
      restart_run();
      halted = 1'b1;
    endfunction

    function void restart_run();
      foreach (tape[i]) tape[i] = 1'b0;
      state   = '0;
      head    = HEAD_CENTER;
      ones    = '0;
      steps   = '0;
      halted  = 1'b0;
      at_edge = 1'b0;
      bad     = 1'b0;
    endfunction

    function logic [SLOT_W-1:0] next_slot();
      return {state, tape[head]};
    endfunction

    // a step is only sent while halted or when the rule it would fire has been loaded
    function bit step_defined();
      return halted || loaded[next_slot()];
    endfunction

    function void note_item(in_item_t it);
      out_item_t st;
      tm_rule_t  r;
      bit        rd;
      bit        wr;
      rd = 1'b0;
      wr = 1'b0;
      case (it.op)
        OP_LOAD: begin
          rules[it.rule_index]  = '{nxt: it.rule_next, mv: it.rule_move, wr: it.rule_write};
          loaded[it.rule_index] = 1'b1;
        end
        OP_STEP: begin
          if (!halted) begin
            rd = tape[head];
            r  = rules[next_slot()];
            wr = r.wr;
            if (!rd && wr) ones = ones + 1'b1;
            if (rd && !wr && ones != 0) ones = ones - 1'b1;
            tape[head] = wr;
            if (steps != STEP_MAX) steps = steps + 1'b1;
            if (r.mv == MOVE_HALT || r.mv == MOVE_SPARE) begin
              halted = 1'b1;
            end else begin
              if (r.mv == MOVE_LEFT) begin
                if (head == '0) begin
                  at_edge = 1'b1;
                  halted  = 1'b1;
                end else begin
                  head = head - 1'b1;
                end
              end else if (head == HEAD_LAST) begin
                at_edge = 1'b1;
                halted  = 1'b1;
              end else begin
                head = head + 1'b1;
              end
              // hold the state on a next state that is not active
              if ({1'b0, r.nxt} >= active) begin
                bad    = 1'b1;
                halted = 1'b1;
              end else begin
                state = r.nxt;
              end
            end
          end
        end
        OP_RESTART: restart_run();
        default: ;
      endcase
      st.state_now      = state;
      st.head_now       = head;
      st.symbol_read    = rd;
      st.symbol_written = wr;
      st.ones_now       = ones;
      st.steps_now      = steps;
      st.halted         = halted;
      st.hit_edge       = at_edge;
      st.bad_rule       = bad;
      status_due.insert(status_due.size(), st);
    endfunction

    function void compare_field(string name, logic [STEP_W-1:0] want, logic [STEP_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected status item, expected none, actual state %0d head %0d",
                 $time, got.state_now, got.head_now);
        return;
      end
      want = status_due.pop_front();
      compare_field("state_now", want.state_now, got.state_now);
      compare_field("head_now", want.head_now, got.head_now);
      compare_field("symbol_read", want.symbol_read, got.symbol_read);
      compare_field("symbol_written", want.symbol_written, got.symbol_written);
      compare_field("ones_now", want.ones_now, got.ones_now);
      compare_field("steps_now", want.steps_now, got.steps_now);
      compare_field("halted", want.halted, got.halted);
      compare_field("hit_edge", want.hit_edge, got.hit_edge);
      compare_field("bad_rule", want.bad_rule, got.bad_rule);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tms_in_if  in_chan();
  tms_out_if out_chan();

  tm_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int stall_cycles  = 0;

  turing_machine_stepper_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      sb.check_status(out_item_t'{
        state_now:      out_chan.state_now,
        head_now:       out_chan.head_now,
        symbol_read:    out_chan.symbol_read,
        symbol_written: out_chan.symbol_written,
        ones_now:       out_chan.ones_now,
        steps_now:      out_chan.steps_now,
        halted:         out_chan.halted,
        hit_edge:       out_chan.hit_edge,
        bad_rule:       out_chan.bad_rule});
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [SLOT_W-1:0] idx, logic wr,
                                         logic [1:0] mv, logic [STATE_W-1:0] nxt);
    in_item_t it;
    it.op         = op;
    it.rule_index = idx;
    it.rule_write = wr;
    it.rule_move  = mv;
    it.rule_next  = nxt;
    return it;
  endfunction

  function automatic in_item_t noise_item();
    logic [31:0] rnd;
    rnd = $urandom;
    return in_item_t'(rnd[$bits(in_item_t)-1:0]);
  endfunction

  // mostly left/right moves into the program's own states
  function automatic tm_rule_t random_rule(int k);
    tm_rule_t r;
    int       pick;
    pick = $urandom_range(19);
    r.wr = 1'($urandom_range(1));
    if (pick == 0) r.mv = MOVE_HALT;
    else if (pick == 1) r.mv = MOVE_SPARE;
    else r.mv = $urandom_range(1) ? MOVE_RIGHT : MOVE_LEFT;
    r.nxt = ($urandom_range(9) == 0) ? STATE_W'($urandom_range(31))
                                     : STATE_W'($urandom_range(k - 1));
    return r;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.op         <= it.op;
    in_chan.rule_index <= it.rule_index;
    in_chan.rule_write <= it.rule_write;
    in_chan.rule_move  <= it.rule_move;
    in_chan.rule_next  <= it.rule_next;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_item(it);
    items_sent++;
  endtask

  // replace a step that would fire an unloaded rule by a load of that rule
  task automatic send_safe(in_item_t it);
    tm_rule_t r;
    if (it.op == OP_STEP && !sb.step_defined()) begin
      r  = random_rule(MAX_STATES);
      it = make_item(OP_LOAD, sb.next_slot(), r.wr, r.mv, r.nxt);
    end
    send_item(it);
  endtask

  task automatic send_op(logic [1:0] op);
    send_safe(make_item(op, '0, 1'b0, MOVE_LEFT, '0));
  endtask

  task automatic load_rule(logic [SLOT_W-1:0] idx, logic wr, logic [1:0] mv,
                           logic [STATE_W-1:0] nxt);
    send_safe(make_item(OP_LOAD, idx, wr, mv, nxt));
  endtask

  task automatic send_step();
    in_item_t it;
    it    = noise_item();
    it.op = OP_STEP;
    send_safe(it);
  endtask

  task automatic run_directed();
    send_op(OP_STEP);
    send_op(OP_IGNORED);
    // two-state champion
    load_rule(SLOT_W'(0), 1'b1, MOVE_RIGHT, STATE_W'(1));
    load_rule(SLOT_W'(1), 1'b1, MOVE_LEFT, STATE_W'(1));
    load_rule(SLOT_W'(2), 1'b1, MOVE_LEFT, STATE_W'(0));
    load_rule(SLOT_W'(3), 1'b1, MOVE_HALT, STATE_W'(31));
    send_op(OP_RESTART);
    repeat (7) send_op(OP_STEP);
    // erase ones instead of halting
    load_rule(SLOT_W'(3), 1'b0, MOVE_RIGHT, STATE_W'(0));
    send_op(OP_RESTART);
    repeat (4) send_op(OP_STEP);
    load_rule(SLOT_W'(0), 1'b1, MOVE_SPARE, STATE_W'(5));
    send_op(OP_RESTART);
    send_op(OP_STEP);
    load_rule(SLOT_W'(0), 1'b0, MOVE_LEFT, STATE_W'(31));
    send_op(OP_RESTART);
    send_op(OP_STEP);
    load_rule(SLOT_W'(63), 1'b1, MOVE_HALT, STATE_W'(31));
    load_rule(SLOT_W'(62), 1'b0, MOVE_RIGHT, STATE_W'(0));
  endtask

  task automatic run_program();
    int       k;
    int       n;
    int       i;
    int       s;
    int       extra;
    tm_rule_t r;
    in_item_t it;
    k = ($urandom_range(9) == 0) ? $urandom_range(5, MAX_STATES) : $urandom_range(1, 4);
    for (s = 0; s < 2 * k; s++) begin
      r = random_rule(k);
      load_rule(SLOT_W'(s), r.wr, r.mv, r.nxt);
    end
    it    = noise_item();
    it.op = OP_RESTART;
    send_safe(it);
    n     = $urandom_range(8, 60);
    extra = 0;
    for (i = 0; i < n && extra < 3; i++) begin
      if ($urandom_range(99) < 8) send_safe(noise_item());
      else send_step();
      if (sb.halted) extra++;
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_active_readback();
    logic [APB_DW-1:0] rdata;
    apb_access(1'b0, ADDR_ACTIVE_STATES, '0, rdata);
    if (rdata[ACT_W-1:0] !== sb.active) begin
      sb.errors++;
      $display("%0t: active_states readback mismatch, expected %0d, actual %0d",
               $time, sb.active, rdata[ACT_W-1:0]);
    end
  endtask

  task automatic set_active(logic [ACT_W-1:0] value);
    logic [APB_DW-1:0] rdata;
    apb_access(1'b1, ADDR_ACTIVE_STATES, APB_DW'(value), rdata);
    sb.active = value;
    check_active_readback();
  endtask

  initial begin
    logic [ACT_W-1:0] level;
    int               phase;
    int               target;
    sb = new();
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.op         <= '0;
    in_chan.rule_index <= '0;
    in_chan.rule_write <= 1'b0;
    in_chan.rule_move  <= '0;
    in_chan.rule_next  <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    check_active_readback();
    set_active(ACT_RESET);

    send_idle_pct = 9;
    recv_idle_pct = 52;
    run_directed();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      if (phase == 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 9;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0, 7:    level = ACT_LIMIT;
        1:       level = ACT_W'(1);
        2:       level = ACT_W'($urandom_range(2, MAX_STATES - 1));
        3:       level = '0;
        4:       level = '1;
        5:       level = ACT_W'($urandom_range(0, 63));
        6:       level = ACT_RESET;
        default: level = ACT_W'($urandom_range(1, MAX_STATES));
      endcase
      set_active(level);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_program();
    end

    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ turing_machine_stepper_core.f @@
rtl/tms_pkg.sv
rtl/tms_in_if.sv
rtl/tms_out_if.sv
rtl/tms_ctrl.sv
rtl/tms_dp.sv
rtl/turing_machine_stepper_core.sv
verif/testbench.sv
